// ===== rtl/circular_deque_sorted_insert_macros.svh =====
`ifndef CIRCULAR_DEQUE_SORTED_INSERT_MACROS_SVH
`define CIRCULAR_DEQUE_SORTED_INSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define CDSI_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define CDSI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/cdsi_pkg.sv =====
`timescale 1ns / 1ps

package cdsi_pkg;

  localparam int unsigned ValueWidth = 32;
  localparam int unsigned CountWidth = 4;
  localparam int unsigned SizeWidth  = 5;
  localparam int unsigned OpWidth    = 3;

  localparam logic [SizeWidth-1:0] RING_SIZE_RST = 5'd16;

  localparam logic [OpWidth-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OpWidth-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OpWidth-1:0] OP_DROP_FRONT = 3'd2;
  localparam logic [OpWidth-1:0] OP_DROP_BACK  = 3'd3;
  localparam logic [OpWidth-1:0] OP_INSERT     = 3'd4;
  localparam logic [OpWidth-1:0] OP_SEARCH     = 3'd5;

  typedef struct packed {
    logic [OpWidth-1:0]           operation;
    logic signed [ValueWidth-1:0] element_value;
  } in_item_t;

  typedef struct packed {
    logic                  ok;
    logic [CountWidth-1:0] entry_count;
  } res_item_t;

endpackage

// ===== rtl/circular_deque_sorted_insert.sv =====
`timescale 1ns / 1ps
// Push, drop, refused insert and unknown codes: result strobe in the cycle after start, busy stays low.
// Search over n held entries: the walk reads one store entry per cycle until a hit or the back; result as busy falls.
// Ordered insert: walk to the first larger entry, shift the shorter side (at most n/2 entries), then place the value.
// The walk and shift steps follow from the single read and single write port of the ring store.
// Reset clears both indices and sets ring_size to 16; store contents stay undefined until written.
// Results last one cycle on res_valid_o; the receiver cannot stall them.

`include "circular_deque_sorted_insert_macros.svh"

module circular_deque_sorted_insert #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  cdsi_pkg::in_item_t                  item_i,
  output logic                                res_valid_o,
  output cdsi_pkg::res_item_t                 res_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [cdsi_pkg::SizeWidth-1:0]      cfg_data_i
);

  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned SW = IW + 1;

  logic [cdsi_pkg::SizeWidth-1:0]  ring_size_q, ring_size_d;
  logic [SW-1:0]                   size_eff;
  logic                            cfg_wr;
  logic                            we, re;
  logic [IW-1:0]                   waddr, raddr;
  logic [cdsi_pkg::ValueWidth-1:0] wdata, rdata;

  assign cfg_ready_o = !busy;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;
  assign ring_size_d = cfg_wr ? cfg_data_i : ring_size_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_size_q <= cdsi_pkg::RING_SIZE_RST;
    end else begin
      ring_size_q <= ring_size_d;
    end
  end

  // clamp the ring to 1..DEPTH slots
  always_comb begin
    if (ring_size_q == '0) begin
      size_eff = SW'(1);
    end else if (int'(ring_size_q) > int'(DEPTH)) begin
      size_eff = SW'(DEPTH);
    end else begin
      size_eff = SW'(ring_size_q);
    end
  end

  cdsi_ctrl #(
    .IW    (IW),
    .SW    (SW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .size_i      (size_eff),
    .clear_i     (cfg_wr),
    .start_i     (start),
    .item_i      (item_i),
    .busy_o      (busy),
    .res_valid_o (res_valid_o),
    .res_o       (res_o),
    .we_o        (we),
    .waddr_o     (waddr),
    .wdata_o     (wdata),
    .re_o        (re),
    .raddr_o     (raddr),
    .rdata_i     (rdata)
  );

  cdsi_ram #(
    .DEPTH (DEPTH),
    .AW    (IW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  `CDSI_ASSERT_IMPL(a_busy_after_start, clk_i, rst_ni, $rose(busy), $past(start), "busy rose without a start")
  `CDSI_ASSERT_IMPL(a_result_at_finish, clk_i, rst_ni, $fell(busy), res_valid_o, "walk ended without a result")
  `CDSI_ASSERT_NEXT(a_short_op_result, clk_i, rst_ni, start && !busy && (item_i.operation != cdsi_pkg::OP_INSERT) && (item_i.operation != cdsi_pkg::OP_SEARCH), res_valid_o, "short item gave no result")
  `CDSI_ASSERT_IMPL(a_count_in_ring, clk_i, rst_ni, res_valid_o, (int'(res_o.entry_count) < int'(size_eff)), "entry count beyond ring")

endmodule

// ===== rtl/cdsi_ram.sv =====
`timescale 1ns / 1ps

module cdsi_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic                              clk_i,
  input  logic                              we_i,
  input  logic [AW-1:0]                     waddr_i,
  input  logic [cdsi_pkg::ValueWidth-1:0]   wdata_i,
  input  logic                              re_i,
  input  logic [AW-1:0]                     raddr_i,
  output logic [cdsi_pkg::ValueWidth-1:0]   rdata_o
);

  logic [cdsi_pkg::ValueWidth-1:0] mem [DEPTH];
  logic [cdsi_pkg::ValueWidth-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/cdsi_ctrl.sv =====
`timescale 1ns / 1ps

module cdsi_ctrl #(
  parameter int unsigned IW    = 4,
  parameter int unsigned SW    = 5
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [SW-1:0]                     size_i,
  input  logic                              clear_i,
  input  logic                              start_i,
  input  cdsi_pkg::in_item_t                item_i,
  output logic                              busy_o,
  output logic                              res_valid_o,
  output cdsi_pkg::res_item_t               res_o,
  output logic                              we_o,
  output logic [IW-1:0]                     waddr_o,
  output logic [cdsi_pkg::ValueWidth-1:0]   wdata_o,
  output logic                              re_o,
  output logic [IW-1:0]                     raddr_o,
  input  logic [cdsi_pkg::ValueWidth-1:0]   rdata_i
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_SHIFT,
    ST_PLACE
  } state_e;

  state_e                               state_q, state_d;
  logic [IW-1:0]                        front_q, front_d;
  logic [IW-1:0]                        back_q, back_d;
  logic [IW-1:0]                        pos_q, pos_d;
  logic [IW-1:0]                        cur_q, cur_d;
  logic signed [cdsi_pkg::ValueWidth-1:0] val_q, val_d;
  logic                                 srch_q, srch_d;
  logic                                 side_q, side_d;
  logic                                 res_valid_q, res_valid_d;
  cdsi_pkg::res_item_t                  res_q, res_d;

  logic          full, empty, at_end, hit, stop;
  logic [SW-1:0] pos_ofs, used;
  logic [IW-1:0] nxt;

  function automatic logic [IW-1:0] ring_inc(input logic [IW-1:0] i, input logic [SW-1:0] s);
    logic [SW-1:0] n;
    n = {1'b0, i} + SW'(1);
    return (n >= s) ? '0 : n[IW-1:0];
  endfunction

  function automatic logic [IW-1:0] ring_dec(input logic [IW-1:0] i, input logic [SW-1:0] s);
    logic [SW-1:0] m;
    m = s - SW'(1);
    return (i == '0) ? m[IW-1:0] : i - IW'(1);
  endfunction

  // distance from b up to a around the ring
  function automatic logic [SW-1:0] ring_dist(input logic [IW-1:0] a, input logic [IW-1:0] b,
                                              input logic [SW-1:0] s);
    return (a >= b) ? ({1'b0, a} - {1'b0, b}) : ({1'b0, a} + s - {1'b0, b});
  endfunction

  assign full    = (front_q == ring_inc(back_q, size_i));
  assign empty   = (front_q == back_q);
  assign at_end  = (pos_q == back_q);
  assign hit     = !at_end && (rdata_i == val_q);
  assign stop    = at_end || ($signed(rdata_i) > val_q);
  assign pos_ofs = ring_dist(pos_q, front_q, size_i);
  assign used    = ring_dist(back_q, front_q, size_i);

  always_comb begin
    state_d     = state_q;
    front_d     = front_q;
    back_d      = back_q;
    pos_d       = pos_q;
    cur_d       = cur_q;
    val_d       = val_q;
    srch_d      = srch_q;
    side_d      = side_q;
    res_d       = res_q;
    res_valid_d = 1'b0;
    we_o        = 1'b0;
    waddr_o     = '0;
    wdata_o     = '0;
    re_o        = 1'b0;
    raddr_o     = '0;
    nxt         = '0;

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          val_d       = item_i.element_value;
          res_valid_d = 1'b1;
          res_d.ok    = 1'b0;
          case (item_i.operation)
            cdsi_pkg::OP_PUSH_FRONT: begin
              if (!full) begin
                front_d  = ring_dec(front_q, size_i);
                we_o     = 1'b1;
                waddr_o  = front_d;
                wdata_o  = item_i.element_value;
                res_d.ok = 1'b1;
              end
            end
            cdsi_pkg::OP_PUSH_BACK: begin
              if (!full) begin
                back_d   = ring_inc(back_q, size_i);
                we_o     = 1'b1;
                waddr_o  = back_q;
                wdata_o  = item_i.element_value;
                res_d.ok = 1'b1;
              end
            end
            cdsi_pkg::OP_DROP_FRONT: begin
              if (!empty) begin
                front_d  = ring_inc(front_q, size_i);
                res_d.ok = 1'b1;
              end
            end
            cdsi_pkg::OP_DROP_BACK: begin
              if (!empty) begin
                back_d   = ring_dec(back_q, size_i);
                res_d.ok = 1'b1;
              end
            end
            cdsi_pkg::OP_INSERT, cdsi_pkg::OP_SEARCH: begin
              // refused insert answers at once; otherwise start the walk
              if (item_i.operation == cdsi_pkg::OP_SEARCH || !full) begin
                res_valid_d = 1'b0;
                srch_d      = (item_i.operation == cdsi_pkg::OP_SEARCH);
                pos_d       = front_q;
                re_o        = 1'b1;
                raddr_o     = front_q;
                state_d     = ST_WALK;
              end
            end
            default: begin
            end
          endcase
          res_d.entry_count = 4'(ring_dist(back_d, front_d, size_i));
        end
      end

      ST_WALK: begin
        if (srch_q) begin
          if (at_end || hit) begin
            res_valid_d       = 1'b1;
            res_d.ok          = hit;
            res_d.entry_count = 4'(used);
            state_d           = ST_IDLE;
          end else begin
            pos_d   = ring_inc(pos_q, size_i);
            re_o    = 1'b1;
            raddr_o = pos_d;
          end
        end else if (!stop) begin
          pos_d   = ring_inc(pos_q, size_i);
          re_o    = 1'b1;
          raddr_o = pos_d;
        end else if (pos_ofs > (used >> 1)) begin
          // open the gap by moving the tail up one slot
          side_d = 1'b1;
          if (back_q == pos_q) begin
            state_d = ST_PLACE;
          end else begin
            cur_d   = back_q;
            re_o    = 1'b1;
            raddr_o = ring_dec(back_q, size_i);
            state_d = ST_SHIFT;
          end
        end else begin
          // open the gap by moving the head down one slot
          side_d = 1'b0;
          if (front_q == pos_q) begin
            state_d = ST_PLACE;
          end else begin
            cur_d   = front_q;
            re_o    = 1'b1;
            raddr_o = front_q;
            state_d = ST_SHIFT;
          end
        end
      end

      ST_SHIFT: begin
        we_o    = 1'b1;
        wdata_o = rdata_i;
        if (side_q) begin
          waddr_o = cur_q;
          nxt     = ring_dec(cur_q, size_i);
          if (nxt == pos_q) begin
            state_d = ST_PLACE;
          end else begin
            re_o    = 1'b1;
            raddr_o = ring_dec(nxt, size_i);
          end
        end else begin
          waddr_o = ring_dec(cur_q, size_i);
          nxt     = ring_inc(cur_q, size_i);
          if (nxt == pos_q) begin
            state_d = ST_PLACE;
          end else begin
            re_o    = 1'b1;
            raddr_o = nxt;
          end
        end
        cur_d = nxt;
      end

      ST_PLACE: begin
        we_o    = 1'b1;
        wdata_o = val_q;
        if (side_q) begin
          waddr_o = pos_q;
          back_d  = ring_inc(back_q, size_i);
        end else begin
          waddr_o = ring_dec(pos_q, size_i);
          front_d = ring_dec(front_q, size_i);
        end
        res_valid_d       = 1'b1;
        res_d.ok          = 1'b1;
        res_d.entry_count = 4'(ring_dist(back_d, front_d, size_i));
        state_d           = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (clear_i) begin
      front_d = '0;
      back_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      front_q     <= '0;
      back_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      front_q     <= front_d;
      back_q      <= back_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q  <= pos_d;
    cur_q  <= cur_d;
    val_q  <= val_d;
    srch_q <= srch_d;
    side_q <= side_d;
    res_q  <= res_d;
  end

  assign busy_o      = (state_q != ST_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// ===== bench/tb_circular_deque_sorted_insert.sv =====
`timescale 1ns / 1ps

module tb_circular_deque_sorted_insert;

  localparam int unsigned DEPTH = 16;
  localparam logic [cdsi_pkg::OpWidth-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [cdsi_pkg::OpWidth-1:0] OP_SPARE_7 = 3'd7;
  localparam int unsigned RANDOM_ITEMS = 1200;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned TAIL_CYCLES = 40;

  typedef enum logic [1:0] {STEP_ITEM, STEP_CFG, STEP_DRAIN} step_kind_e;

  typedef struct {
    step_kind_e                      kind;
    cdsi_pkg::in_item_t              item;
    logic [cdsi_pkg::SizeWidth-1:0]  size;
    int                              gap;
  } step_t;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            start = 1'b0;
  logic                            busy;
  cdsi_pkg::in_item_t              item_i = '0;
  logic                            res_valid_o;
  cdsi_pkg::res_item_t             res_o;
  logic                            cfg_valid_i = 1'b0;
  logic                            cfg_ready_o;
  logic [cdsi_pkg::SizeWidth-1:0]  cfg_data_i = '0;

  step_t                plan_q[$];
  cdsi_pkg::res_item_t  expected_q[$];
  int unsigned sent_cnt = 0;
  int unsigned taken_cnt = 0;
  int unsigned cfg_sent = 0;
  int unsigned cfg_done = 0;
  int unsigned quiet_cnt = 0;
  int unsigned err_cnt = 0;

  // Shadow copy of the deque state
  logic signed [cdsi_pkg::ValueWidth-1:0] ring_mem [DEPTH];
  int unsigned head_idx = 0;
  int unsigned tail_idx = 0;
  logic [cdsi_pkg::SizeWidth-1:0] size_reg = cdsi_pkg::RING_SIZE_RST;

  circular_deque_sorted_insert #(
    .DEPTH(DEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .item_i     (item_i),
    .res_valid_o(res_valid_o),
    .res_o      (res_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  function automatic cdsi_pkg::res_item_t deque_apply(cdsi_pkg::in_item_t it);
    int unsigned s;
    int unsigned pos;
    int unsigned n;
    int unsigned c;
    logic signed [cdsi_pkg::ValueWidth-1:0] v;
    logic ok;
    logic full;
    cdsi_pkg::res_item_t r;
    s = size_reg;
    if (s < 1) s = 1;
    if (s > DEPTH) s = DEPTH;
    v = it.element_value;
    ok = 1'b0;
    full = (head_idx == (tail_idx + 1) % s);
    case (it.operation)
      cdsi_pkg::OP_PUSH_FRONT: begin
        if (!full) begin
          head_idx = (head_idx + s - 1) % s;
          ring_mem[head_idx] = v;
          ok = 1'b1;
        end
      end
      cdsi_pkg::OP_PUSH_BACK: begin
        if (!full) begin
          ring_mem[tail_idx] = v;
          tail_idx = (tail_idx + 1) % s;
          ok = 1'b1;
        end
      end
      cdsi_pkg::OP_DROP_FRONT: begin
        if (head_idx != tail_idx) begin
          head_idx = (head_idx + 1) % s;
          ok = 1'b1;
        end
      end
      cdsi_pkg::OP_DROP_BACK: begin
        if (head_idx != tail_idx) begin
          tail_idx = (tail_idx + s - 1) % s;
          ok = 1'b1;
        end
      end
      cdsi_pkg::OP_INSERT: begin
        if (!full) begin
          pos = head_idx;
          while (pos != tail_idx && ring_mem[pos] <= v) pos = (pos + 1) % s;
          n = (tail_idx + s - head_idx) % s;
          // shift the shorter side to open a slot
          if ((pos + s - head_idx) % s > n / 2) begin
            for (c = tail_idx; c != pos; c = (c + s - 1) % s)
              ring_mem[c] = ring_mem[(c + s - 1) % s];
            ring_mem[pos] = v;
            tail_idx = (tail_idx + 1) % s;
          end else begin
            for (c = head_idx; c != pos; c = (c + 1) % s)
              ring_mem[(c + s - 1) % s] = ring_mem[c];
            ring_mem[(pos + s - 1) % s] = v;
            head_idx = (head_idx + s - 1) % s;
          end
          ok = 1'b1;
        end
      end
      cdsi_pkg::OP_SEARCH: begin
        pos = head_idx;
        while (pos != tail_idx && !ok) begin
          if (ring_mem[pos] == v) ok = 1'b1;
          pos = (pos + 1) % s;
        end
      end
      default: ;
    endcase
    r.ok = ok;
    n = (tail_idx + s - head_idx) % s;
    r.entry_count = n[cdsi_pkg::CountWidth-1:0];
    return r;
  endfunction

  // Driver: one item or register write at a time, changes on the falling edge
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (expected_q.size() == 0 && !busy && !start && !cfg_valid_i)
        quiet_cnt <= quiet_cnt + 1;
      else
        quiet_cnt <= 0;
      if (start) begin
        if (taken_cnt == sent_cnt) begin
          // keep start high when the next item has no gap
          if (plan_q.size() != 0 && plan_q[0].kind == STEP_ITEM && plan_q[0].gap == 0) begin
            item_i <= plan_q[0].item;
            sent_cnt <= sent_cnt + 1;
            void'(plan_q.pop_front());
          end else begin
            start <= 1'b0;
          end
        end
      end else if (cfg_valid_i) begin
        if (cfg_done == cfg_sent) cfg_valid_i <= 1'b0;
      end else if (plan_q.size() != 0) begin
        case (plan_q[0].kind)
          STEP_ITEM: begin
            if (plan_q[0].gap > 0) begin
              plan_q[0].gap = plan_q[0].gap - 1;
            end else begin
              start <= 1'b1;
              item_i <= plan_q[0].item;
              sent_cnt <= sent_cnt + 1;
              void'(plan_q.pop_front());
            end
          end
          STEP_CFG: begin
            if (quiet_cnt >= SETTLE_CYCLES) begin
              cfg_data_i <= plan_q[0].size;
              cfg_valid_i <= 1'b1;
              cfg_sent <= cfg_sent + 1;
              void'(plan_q.pop_front());
            end
          end
          default: begin
            if (expected_q.size() == 0) void'(plan_q.pop_front());
          end
        endcase
      end
    end
  end

  // Monitor: check results, predict on accepted items, track register writes
  always @(posedge clk_i) begin
    cdsi_pkg::res_item_t want;
    if (rst_ni) begin
      if (res_valid_o) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual ok=%0b count=%0d",
                   $time, res_o.ok, res_o.entry_count);
          err_cnt <= err_cnt + 1;
        end else begin
          want = expected_q.pop_front();
          if (res_o !== want) begin
            $display("%0t: result mismatch, expected ok=%0b count=%0d, actual ok=%0b count=%0d",
                     $time, want.ok, want.entry_count, res_o.ok, res_o.entry_count);
            err_cnt <= err_cnt + 1;
          end
        end
      end
      if (start && !busy) begin
        expected_q.push_back(deque_apply(item_i));
        taken_cnt <= taken_cnt + 1;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        size_reg = cfg_data_i;
        head_idx = 0;
        tail_idx = 0;
        cfg_done <= cfg_done + 1;
      end
    end
  end

  task automatic plan_item(logic [cdsi_pkg::OpWidth-1:0] op,
                           logic [cdsi_pkg::ValueWidth-1:0] val, int gap);
    step_t st;
    st.kind = STEP_ITEM;
    st.item.operation = op;
    st.item.element_value = val;
    st.size = '0;
    st.gap = gap;
    plan_q.push_back(st);
  endtask

  task automatic plan_cfg(logic [cdsi_pkg::SizeWidth-1:0] size);
    step_t st;
    st.kind = STEP_CFG;
    st.item = '0;
    st.size = size;
    st.gap = 0;
    plan_q.push_back(st);
  endtask

  task automatic plan_drain();
    step_t st;
    st.kind = STEP_DRAIN;
    st.item = '0;
    st.size = '0;
    st.gap = 0;
    plan_q.push_back(st);
  endtask

  // Mostly small values so searches hit and inserts see duplicates
  function automatic logic [cdsi_pkg::ValueWidth-1:0] pick_value();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll < 6) return 32'($signed($urandom_range(0, 12)) - 6);
    if (roll == 6) return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
    return $urandom;
  endfunction

  function automatic logic [cdsi_pkg::OpWidth-1:0] pick_op(int unsigned grow_pct);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 3) return $urandom_range(0, 1) ? OP_SPARE_6 : OP_SPARE_7;
    if (roll < 18) return cdsi_pkg::OP_SEARCH;
    if (roll < grow_pct) begin
      case ($urandom_range(0, 3))
        0: return cdsi_pkg::OP_PUSH_FRONT;
        1: return cdsi_pkg::OP_PUSH_BACK;
        default: return cdsi_pkg::OP_INSERT;
      endcase
    end
    return $urandom_range(0, 1) ? cdsi_pkg::OP_DROP_FRONT : cdsi_pkg::OP_DROP_BACK;
  endfunction

  initial begin
    logic [cdsi_pkg::SizeWidth-1:0] first_sizes [7];
    logic [cdsi_pkg::SizeWidth-1:0] size;
    int unsigned done_items;
    int unsigned phase;
    int unsigned len;
    int unsigned k;
    bit no_idle;
    int gap;

    first_sizes = '{5'd1, 5'd16, 5'd2, 5'd0, 5'd31, 5'd17, 5'd15};

    // directed part, ring size 16 after reset
    plan_item(cdsi_pkg::OP_SEARCH, 32'd0, 0);
    plan_item(cdsi_pkg::OP_DROP_FRONT, 32'hFFFF_FFFF, 0);
    plan_item(cdsi_pkg::OP_DROP_BACK, 32'd0, 3);
    plan_item(cdsi_pkg::OP_PUSH_BACK, 32'h7FFF_FFFF, 0);
    plan_item(cdsi_pkg::OP_PUSH_FRONT, 32'h8000_0000, 0);
    plan_item(cdsi_pkg::OP_SEARCH, 32'h7FFF_FFFF, 0);
    plan_item(cdsi_pkg::OP_SEARCH, 32'h8000_0000, 2);
    plan_item(cdsi_pkg::OP_SEARCH, 32'd1, 0);
    plan_item(cdsi_pkg::OP_INSERT, 32'd0, 0);
    plan_item(cdsi_pkg::OP_INSERT, 32'hFFFF_FFFF, 0);
    plan_item(cdsi_pkg::OP_INSERT, 32'h7FFF_FFFF, 1);
    plan_item(cdsi_pkg::OP_INSERT, 32'h8000_0000, 0);
    plan_item(OP_SPARE_6, 32'd7, 0);
    plan_item(OP_SPARE_7, 32'hFFFF_FFFF, 0);
    plan_item(cdsi_pkg::OP_DROP_FRONT, 32'd0, 0);
    plan_item(cdsi_pkg::OP_DROP_BACK, 32'd0, 0);
    plan_drain();
    // single slot: always full and empty
    plan_cfg(5'd1);
    plan_item(cdsi_pkg::OP_PUSH_BACK, 32'd5, 0);
    plan_item(cdsi_pkg::OP_INSERT, 32'd5, 0);
    plan_item(cdsi_pkg::OP_DROP_FRONT, 32'd0, 0);
    plan_item(cdsi_pkg::OP_SEARCH, 32'd5, 0);
    plan_cfg(5'd3);
    plan_item(cdsi_pkg::OP_PUSH_FRONT, 32'd1, 0);
    plan_item(cdsi_pkg::OP_PUSH_BACK, 32'd2, 0);
    plan_item(cdsi_pkg::OP_PUSH_BACK, 32'd3, 0);
    plan_item(cdsi_pkg::OP_INSERT, 32'd0, 0);
    plan_item(cdsi_pkg::OP_DROP_BACK, 32'd0, 0);

    // random phases, each with a fresh ring size
    done_items = 0;
    phase = 0;
    while (done_items < RANDOM_ITEMS) begin
      if (phase < 7)
        size = first_sizes[phase];
      else if ($urandom_range(0, 5) == 0)
        size = $urandom_range(0, 31);
      else
        size = $urandom_range(2, 16);
      plan_cfg(size);
      len = $urandom_range(40, 120);
      no_idle = ($urandom_range(0, 3) == 0);
      for (k = 0; k < len; k++) begin
        gap = no_idle ? 0 : $urandom_range(0, 17);
        // grow through the first part of the phase, then drain
        plan_item(pick_op(k < len * 3 / 5 ? 85 : 45), pick_value(), gap);
        if ($urandom_range(0, 39) == 0) plan_drain();
      end
      done_items += len;
      phase++;
    end

    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (plan_q.size() != 0 || start || cfg_valid_i || expected_q.size() != 0)
      @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (err_cnt == 0 && expected_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

endmodule
